// ----- src/pmt_pkg.sv -----
// Package for the prescaled match timer: command codes, register indexes,
// beat structs and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package pmt_pkg;

    localparam int MATCH_CHANNELS = 4;
    localparam int COUNT_W        = 32;
    localparam int FLAG_W         = 4;
    localparam int DATA_W         = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_VALUE_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_CONTROL  = 3'd5;

    // match_control layout: per channel a group of three bits
    localparam int MC_STRIDE     = 3;
    localparam int MC_IRQ_EN_OFS = 0;
    localparam int MC_RESET_OFS  = 1;

    // control write bits
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_HOLD_BIT   = 1;

    typedef enum logic [1:0] {
        CMD_TICK          = 2'd0,
        CMD_WRITE_CONTROL = 2'd1,
        CMD_CLEAR_FLAGS   = 2'd2,
        CMD_READ_STATUS   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [DATA_W-1:0] write_data;
    } pmt_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [COUNT_W-1:0] prescale_value;
        logic [FLAG_W-1:0]  match_flags;
        logic               interrupt_line;
        logic               counting;
    } pmt_out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                     prescale_limit;
        logic [MATCH_CHANNELS-1:0][COUNT_W-1:0] match_value;
        logic [MATCH_CHANNELS-1:0]              irq_en;
        logic [MATCH_CHANNELS-1:0]              reset_on_match;
    } pmt_cfg_t;

endpackage

// ----- src/pmt_cfg_regs.sv -----
// Configuration register file of the prescaled match timer.
// Depends on pmt_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps

module pmt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pmt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pmt_pkg::pmt_cfg_t              cfg
);
    import pmt_pkg::*;

    pmt_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PRESCALE_LIMIT)
            begin
                cfg_reg.prescale_limit <= cfg_data[COUNT_W-1:0];
            end
            for (int ch = 0; ch < MATCH_CHANNELS; ch++)
            begin
                if (cfg_index == REG_MATCH_VALUE_0 + CFG_INDEX_W'(ch))
                begin
                    cfg_reg.match_value[ch] <= cfg_data[COUNT_W-1:0];
                end
            end
            if (cfg_index == REG_MATCH_CONTROL)
            begin
                for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                begin
                    cfg_reg.irq_en[ch]         <= cfg_data[MC_STRIDE*ch + MC_IRQ_EN_OFS];
                    cfg_reg.reset_on_match[ch] <= cfg_data[MC_STRIDE*ch + MC_RESET_OFS];
                end
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/pmt_core.sv -----
// Timer state and its next-state logic: prescaler, count, match flags.
// Depends on pmt_pkg; fed by pmt_cfg_regs, driven by the top level pipeline.
`timescale 1ns / 1ps

module pmt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  pmt_pkg::pmt_in_t  item,
    input  pmt_pkg::pmt_cfg_t cfg,
    output pmt_pkg::pmt_out_t result
);
    import pmt_pkg::*;

    logic [COUNT_W-1:0]        timer_count_reg, timer_count_next;
    logic [COUNT_W-1:0]        prescale_count_reg, prescale_count_next;
    logic                      count_enable_reg, count_enable_next;
    logic                      reset_hold_reg, reset_hold_next;
    logic [MATCH_CHANNELS-1:0] pending_flags_reg, pending_flags_next;
    logic [MATCH_CHANNELS-1:0] hit;

    always_comb
    begin
        for (int ch = 0; ch < MATCH_CHANNELS; ch++)
        begin
            hit[ch] = (cfg.match_value[ch] == timer_count_reg);
        end
    end

    always_comb
    begin
        timer_count_next    = timer_count_reg;
        prescale_count_next = prescale_count_reg;
        count_enable_next   = count_enable_reg;
        reset_hold_next     = reset_hold_reg;
        pending_flags_next  = pending_flags_reg;
        unique case (item.command)
            CMD_TICK:
            begin
                if (reset_hold_reg)
                begin
                    timer_count_next    = '0;
                    prescale_count_next = '0;
                end
                else if (count_enable_reg)
                begin
                    if (prescale_count_reg == cfg.prescale_limit)
                    begin
                        prescale_count_next = '0;
                        pending_flags_next  = pending_flags_reg | (hit & cfg.irq_en);
                        if (|(hit & cfg.reset_on_match))
                        begin
                            timer_count_next = '0;
                        end
                        else
                        begin
                            timer_count_next = timer_count_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        prescale_count_next = prescale_count_reg + COUNT_W'(1);
                    end
                end
            end
            CMD_WRITE_CONTROL:
            begin
                count_enable_next = item.write_data[CTRL_ENABLE_BIT];
                reset_hold_next   = item.write_data[CTRL_HOLD_BIT];
            end
            CMD_CLEAR_FLAGS:
            begin
                pending_flags_next = pending_flags_reg & ~item.write_data[MATCH_CHANNELS-1:0];
            end
            CMD_READ_STATUS:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_count_reg    <= '0;
            prescale_count_reg <= '0;
            count_enable_reg   <= 1'b0;
            reset_hold_reg     <= 1'b0;
            pending_flags_reg  <= '0;
        end
        else if (step)
        begin
            timer_count_reg    <= timer_count_next;
            prescale_count_reg <= prescale_count_next;
            count_enable_reg   <= count_enable_next;
            reset_hold_reg     <= reset_hold_next;
            pending_flags_reg  <= pending_flags_next;
        end
    end

    always_comb
    begin
        result.count_value    = timer_count_next;
        result.prescale_value = prescale_count_next;
        result.match_flags    = FLAG_W'(pending_flags_next);
        result.interrupt_line = |pending_flags_next;
        result.counting       = count_enable_next & ~reset_hold_next;
    end

    a_no_tick_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.command != CMD_TICK
        |=> $stable(timer_count_reg) && $stable(prescale_count_reg))
        else $error("counters moved without a tick");

    a_hold_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.command == CMD_TICK && reset_hold_reg
        |=> timer_count_reg == '0 && prescale_count_reg == '0)
        else $error("reset hold did not zero the counters");

    a_flags_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.command != CMD_TICK
        |=> (pending_flags_reg & ~$past(pending_flags_reg)) == '0)
        else $error("flag set without a tick");

endmodule

// ----- src/prescaled_match_timer.sv -----
// Top level of the prescaled match timer: input stage, result stage, handshakes.
// Depends on pmt_pkg, pmt_cfg_regs and pmt_core.
//
//  channel  | direction | handshake             | beat
//  in       | in        | in_valid / in_ready   | in_data   (pmt_in_t)
//  out      | out       | out_valid / out_ready | out_data  (pmt_out_t)
//  cfg      | in        | cfg_we                | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high. An accepted beat waits in
// the input register, then the state update loads its result into the result stage.
// The update of the 32-bit count and its four compares sets the rate.
// Reset clears the valid flags, timer state and configuration registers to zero.
// With out_ready low one more beat is taken into an empty input stage, then in_ready drops.
`timescale 1ns / 1ps

module prescaled_match_timer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pmt_pkg::pmt_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pmt_pkg::pmt_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [pmt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pmt_pkg::*;

    logic      in_valid_reg;
    pmt_in_t   in_item_reg;
    logic      out_valid_reg;
    pmt_out_t  out_data_reg;
    logic      out_adv;
    logic      step;
    pmt_cfg_t  cfg;
    pmt_out_t  result;

    assign out_adv  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_adv;
    assign in_ready = !in_valid_reg || out_adv;

    pmt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed beat did not reach the result stage");

    a_stalled_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input stage lost its beat");

    a_irq_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.interrupt_line == (|out_data_reg.match_flags))
        else $error("interrupt line disagrees with pending flags");

endmodule

// ----- dv/testbench.sv -----
// Testbench for prescaled_match_timer: a queue-fed driver, a clocked monitor and a
// timer predictor check every status beat over several register settings.
// Depends on pmt_pkg and the prescaled_match_timer RTL.
`timescale 1ns / 1ps

module testbench;

    import pmt_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int CFG_REGS     = 2 ** CFG_INDEX_W;
    localparam int CTRL_W       = MC_STRIDE * MATCH_CHANNELS;
    localparam int RANDOM_BEATS = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    pmt_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    pmt_out_t               out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    prescaled_match_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // timer predictor state and register copies
    logic [COUNT_W-1:0] prescale_limit;
    logic [COUNT_W-1:0] match_value [MATCH_CHANNELS];
    logic [CTRL_W-1:0]  match_control;
    logic [COUNT_W-1:0] timer_count;
    logic [COUNT_W-1:0] prescale_count;
    logic               count_enable;
    logic               reset_hold;
    logic [FLAG_W-1:0]  pending_flags;

    logic [CFG_DATA_W-1:0] next_regs [CFG_REGS];

    pmt_in_t  pending_beats [$];
    pmt_out_t expected_status [$];
    int       beats_queued   = 0;
    int       status_checked = 0;
    int       mismatches     = 0;
    int       cycle_count    = 0;
    int       idle_pct       = 0;
    int       stall_pct      = 0;
    int       hold_off_request = 0;
    int       hold_off_left    = 0;
    logic     in_taken       = 1'b0;

    function automatic pmt_out_t timer_step(pmt_in_t beat);
        pmt_out_t status;
        logic     zero_count;
        case (beat.command)
            CMD_TICK:
            begin
                if (reset_hold)
                begin
                    timer_count    = '0;
                    prescale_count = '0;
                end
                else if (count_enable)
                begin
                    if (prescale_count == prescale_limit)
                    begin
                        prescale_count = '0;
                        zero_count     = 1'b0;
                        for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                        begin
                            if (match_value[ch] == timer_count)
                            begin
                                if (match_control[MC_STRIDE * ch + MC_IRQ_EN_OFS])
                                    pending_flags[ch] = 1'b1;
                                if (match_control[MC_STRIDE * ch + MC_RESET_OFS])
                                    zero_count = 1'b1;
                            end
                        end
                        timer_count = zero_count ? '0 : timer_count + COUNT_W'(1);
                    end
                    else
                    begin
                        prescale_count = prescale_count + COUNT_W'(1);
                    end
                end
            end
            CMD_WRITE_CONTROL:
            begin
                count_enable = beat.write_data[CTRL_ENABLE_BIT];
                reset_hold   = beat.write_data[CTRL_HOLD_BIT];
            end
            CMD_CLEAR_FLAGS:
                pending_flags = pending_flags & ~beat.write_data[FLAG_W-1:0];
            default:
                ;
        endcase
        status.count_value    = timer_count;
        status.prescale_value = prescale_count;
        status.match_flags    = pending_flags;
        status.interrupt_line = |pending_flags;
        status.counting       = count_enable && !reset_hold;
        return status;
    endfunction

    function automatic pmt_in_t random_beat();
        pmt_in_t beat;
        int      pick;
        pick            = $urandom_range(0, 99);
        beat.write_data = DATA_W'($urandom);
        if (pick < 70)
        begin
            beat.command = CMD_TICK;
        end
        else if (pick < 80)
        begin
            beat.command = CMD_WRITE_CONTROL;
            beat.write_data[CTRL_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
            beat.write_data[CTRL_HOLD_BIT]   = ($urandom_range(0, 9) == 0);
        end
        else if (pick < 90)
        begin
            beat.command = CMD_CLEAR_FLAGS;
        end
        else
        begin
            beat.command = CMD_READ_STATUS;
        end
        return beat;
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_beat(cmd_t command, logic [DATA_W-1:0] write_data);
        pmt_in_t beat;
        beat.command    = command;
        beat.write_data = write_data;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic wait_drained();
        wait (status_checked == beats_queued);
        repeat (4) @(posedge clk);
    endtask

    // write every index, stray ones included, then drop the write enable
    task automatic program_timer();
        logic [CFG_INDEX_W-1:0] idx;
        for (int i = 0; i < CFG_REGS; i++)
        begin
            idx = CFG_INDEX_W'(i);
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= next_regs[i];
            if (idx == REG_PRESCALE_LIMIT)
                prescale_limit = next_regs[i];
            else if (idx >= REG_MATCH_VALUE_0 && idx < REG_MATCH_VALUE_0 + MATCH_CHANNELS)
                match_value[idx - REG_MATCH_VALUE_0] = next_regs[i];
            else if (idx == REG_MATCH_CONTROL)
                match_control = next_regs[i][CTRL_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    // driver: offer the next beat, hold it until taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off on request, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_off_request > 0)
        begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge clk)
    begin
        pmt_out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
        begin
            in_taken = in_valid && in_ready;
            if (rst_n && in_valid && in_ready)
                expected_status.push_back(timer_step(in_data));
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0h",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("count_value", want.count_value, out_data.count_value);
                    check_field("prescale_value", want.prescale_value,
                                out_data.prescale_value);
                    check_field("match_flags", COUNT_W'(want.match_flags),
                                COUNT_W'(out_data.match_flags));
                    check_field("interrupt_line", COUNT_W'(want.interrupt_line),
                                COUNT_W'(out_data.interrupt_line));
                    check_field("counting", COUNT_W'(want.counting),
                                COUNT_W'(out_data.counting));
                    status_checked++;
                end
            end
        end
    end

    initial
    begin
        prescale_limit = '0;
        match_control  = '0;
        timer_count    = '0;
        prescale_count = '0;
        count_enable   = 1'b0;
        reset_hold     = 1'b0;
        pending_flags  = '0;
        for (int ch = 0; ch < MATCH_CHANNELS; ch++)
            match_value[ch] = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: hold, stop, control bits, matches on channels 0..2, clears
        next_regs = '{default: '0};
        next_regs[REG_PRESCALE_LIMIT]    = 1;
        next_regs[REG_MATCH_VALUE_0]     = 0;
        next_regs[REG_MATCH_VALUE_0 + 1] = 2;
        next_regs[REG_MATCH_VALUE_0 + 2] = 4;
        next_regs[REG_MATCH_VALUE_0 + 3] = 32'hFFFF_FFFF;
        next_regs[REG_MATCH_CONTROL]     = 32'h0000_06C9;
        next_regs[REG_MATCH_CONTROL + 1] = 32'hA5A5_5A5A;
        next_regs[REG_MATCH_CONTROL + 2] = 32'hFFFF_FFFF;
        program_timer();

        queue_beat(CMD_READ_STATUS, 4'hF);
        queue_beat(CMD_TICK, 4'h0);
        queue_beat(CMD_CLEAR_FLAGS, 4'hF);
        queue_beat(CMD_WRITE_CONTROL, 4'hC);
        queue_beat(CMD_WRITE_CONTROL, 4'h3);
        queue_beat(CMD_TICK, 4'hF);
        queue_beat(CMD_WRITE_CONTROL, 4'h2);
        queue_beat(CMD_TICK, 4'h5);
        queue_beat(CMD_WRITE_CONTROL, 4'h1);
        repeat (12) queue_beat(CMD_TICK, 4'hA);
        queue_beat(CMD_READ_STATUS, 4'h0);
        queue_beat(CMD_CLEAR_FLAGS, 4'h1);
        queue_beat(CMD_CLEAR_FLAGS, 4'hE);
        queue_beat(CMD_WRITE_CONTROL, 4'hB);
        queue_beat(CMD_TICK, 4'h0);
        queue_beat(CMD_WRITE_CONTROL, 4'h0);
        queue_beat(CMD_TICK, 4'h0);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 50; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase

            for (int i = 0; i < CFG_REGS; i++)
                next_regs[i] = $urandom;
            case (phase)
                0:
                begin
                    next_regs[REG_PRESCALE_LIMIT] = 0;
                    for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                        next_regs[REG_MATCH_VALUE_0 + ch] = $urandom_range(0, 15);
                end
                1:
                begin
                    for (int i = REG_PRESCALE_LIMIT; i <= REG_MATCH_CONTROL; i++)
                        next_regs[i] = 32'hFFFF_FFFF;
                end
                2:
                begin
                    next_regs[REG_PRESCALE_LIMIT] = 0;
                    for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                        next_regs[REG_MATCH_VALUE_0 + ch] = 0;
                    next_regs[REG_MATCH_CONTROL] = 32'h0000_0FFF;
                end
                3:
                begin
                    next_regs[REG_PRESCALE_LIMIT] = $urandom_range(0, 2);
                    for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                        next_regs[REG_MATCH_VALUE_0 + ch] = $urandom_range(0, 10);
                    next_regs[REG_MATCH_CONTROL] = 0;
                end
                default:
                begin
                    next_regs[REG_PRESCALE_LIMIT] = $urandom_range(0, 3);
                    for (int ch = 0; ch < MATCH_CHANNELS; ch++)
                        next_regs[REG_MATCH_VALUE_0 + ch] = $urandom_range(0, 24);
                end
            endcase
            program_timer();

            queue_beat(CMD_WRITE_CONTROL, 4'h1);
            for (int n = 0; n < RANDOM_BEATS; n++)
                pending_beats.push_back(random_beat());
            beats_queued += RANDOM_BEATS;
            if (phase == 4)
                hold_off_request = 60;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
